### src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the go-back-n sender, its window ram and its
// port checker.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int MAX_WINDOW_DEF = 8;
	localparam int PAYLOAD_BITS   = 32;
	localparam int SEQ_BITS       = 8;
	localparam int WIN_BITS       = 4;
	localparam int MOD_BITS       = 9;
	localparam int CFG_IDX_BITS   = 1;

	localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(4);
	localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(8);
	localparam logic [MOD_BITS-1:0] MOD_MIN   = MOD_BITS'(2);
	localparam logic [MOD_BITS-1:0] MOD_MAX   = MOD_BITS'(256);

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'b1;

	// opcodes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// result status codes
	localparam logic [2:0] ST_SENT     = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_ACK_OK   = 3'd2;
	localparam logic [2:0] ST_ACK_BAD  = 3'd3;
	localparam logic [2:0] ST_ACK_OUT  = 3'd4;
	localparam logic [2:0] ST_TIMEOUT  = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RETX,
		S_NORM
	} state_t;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_BITS-1:0]     ack_number;
		logic                    ack_checksum_ok;
		logic [SEQ_BITS-1:0]     timer_seq;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              status;
		logic                    packet_valid;
		logic [SEQ_BITS-1:0]     packet_seq;
		logic [PAYLOAD_BITS-1:0] packet_payload;
		logic                    timer_stop;
		logic [SEQ_BITS-1:0]     timer_stop_seq;
		logic                    timer_start;
		logic [SEQ_BITS-1:0]     timer_start_seq;
		logic                    last;
	} out_item_t;

endpackage

### src/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = gbn_pkg::PAYLOAD_BITS,
	parameter int DEPTH = gbn_pkg::MAX_WINDOW_DEF
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-n sender: window of outstanding payloads kept in a ring ram, sends,
// takes acks and retransmits the whole window on a timer expiry.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   --------------------------------------
//  item      start / busy            item   (gbn_pkg::in_item_t)
//  result    result_valid strobe     result (gbn_pkg::out_item_t)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  send and ack: busy in the exec state after the start edge, result shown
//  in the cycle after that, so a new item can be taken while it is shown.
//  timeout with k packets outstanding: k results back to back, one ram read
//  each, busy through the exec and walk states; with none outstanding, one result.
//  a modulus write re-reduces base and next sequence numbers by bit-serial
//  remainder, busy until done. reset clears all control state but the walk
//  and remainder registers; the window ram needs no clearing pass.
//  the receiver cannot stall: each result is shown for one cycle only.
//
module go_back_n_sender #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  gbn_pkg::in_item_t                     item,
	output logic                                  result_valid,
	output gbn_pkg::out_item_t                    result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gbn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [gbn_pkg::MOD_BITS-1:0]          cfg_data
);

	localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int EW  = (CW > gbn_pkg::WIN_BITS) ? CW : gbn_pkg::WIN_BITS;
	localparam int AW  = CW + 1;
	localparam int QB  = gbn_pkg::SEQ_BITS;
	localparam int MB  = gbn_pkg::MOD_BITS;
	localparam int STW = $clog2(QB);

	gbn_pkg::state_t state_q, state_d;

	gbn_pkg::in_item_t             in_q;
	logic [gbn_pkg::WIN_BITS-1:0]  win_q;
	logic [MB-1:0]                 mod_q;
	logic [QB-1:0]                 base_q, base_d, next_q, next_d;
	logic [QB-1:0]                 bred_q, bred_d, nred_q, nred_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [SW-1:0]                 head_q, head_d;

	logic [SW-1:0]                 ptr_q, ptr_d;
	logic [CW-1:0]                 remain_q, remain_d;
	logic [QB-1:0]                 seqr_q, seqr_d;
	logic                          first_q, first_d;

	logic [QB-1:0]                 sb_q, sb_d, sn_q, sn_d;
	logic [MB-1:0]                 rb_q, rb_d, rn_q, rn_d;
	logic [STW-1:0]                step_q, step_d;

	gbn_pkg::out_item_t            res_q, res_d;
	logic                          res_valid_q, res_valid_d;

	logic                          ram_we, ram_re;
	logic [SW-1:0]                 ram_waddr, ram_raddr;
	logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_rdata;

	logic                          accept, cfg_wr;
	logic [MB-1:0]                 m_eff;
	logic [EW-1:0]                 w_eff;
	logic                          full;
	logic [AW-1:0]                 wslot_sum, hsum;
	logic [SW-1:0]                 wslot, head_adv, head_inc, ptr_inc;
	logic [MB-1:0]                 n_inc, s_inc, ack9, b9, off9, bsum;
	logic [QB-1:0]                 next_wrap, seq_wrap, new_b;
	logic                          off_out;
	logic [CW-1:0]                 adv, count_after;
	logic [MB:0]                   tb, tn, m10;
	logic [MB-1:0]                 rb_new, rn_new;

	assign busy      = (state_q != gbn_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = (state_q == gbn_pkg::S_IDLE) && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign result       = res_q;
	assign result_valid = res_valid_q;

	// effective register values, out-of-range codes clamped
	always_comb begin
		if (mod_q < gbn_pkg::MOD_MIN) begin
			m_eff = gbn_pkg::MOD_MIN;
		end else if (mod_q > gbn_pkg::MOD_MAX) begin
			m_eff = gbn_pkg::MOD_MAX;
		end else begin
			m_eff = mod_q;
		end
		if (win_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(win_q) > EW'(MAX_WINDOW)) begin
			w_eff = EW'(MAX_WINDOW);
		end else begin
			w_eff = EW'(win_q);
		end
	end

	// send path
	assign full      = EW'(count_q) >= w_eff;
	assign wslot_sum = AW'(head_q) + AW'(count_q);
	assign wslot     = (wslot_sum >= AW'(MAX_WINDOW)) ? SW'(wslot_sum - AW'(MAX_WINDOW))
	                                                  : SW'(wslot_sum);
	assign n_inc     = {1'b0, nred_q} + MB'(1);
	assign next_wrap = (n_inc == m_eff) ? '0 : n_inc[QB-1:0];

	// ack path: offset from base taken modulo m with one compare
	assign ack9        = {1'b0, in_q.ack_number};
	assign b9          = {1'b0, bred_q};
	assign off9        = (ack9 >= b9) ? (ack9 - b9) : (ack9 + m_eff - b9);
	assign off_out     = off9 >= MB'(count_q);
	assign adv         = CW'(off9 + MB'(1));
	assign count_after = count_q - adv;
	assign hsum        = AW'(head_q) + AW'(adv);
	assign head_adv    = (hsum >= AW'(MAX_WINDOW)) ? SW'(hsum - AW'(MAX_WINDOW)) : SW'(hsum);
	assign bsum        = b9 + MB'(adv);
	assign new_b       = (bsum >= m_eff) ? QB'(bsum - m_eff) : bsum[QB-1:0];

	// retransmit walk
	assign head_inc = (head_q == SW'(MAX_WINDOW - 1)) ? '0 : SW'(head_q + SW'(1));
	assign ptr_inc  = (ptr_q == SW'(MAX_WINDOW - 1)) ? '0 : SW'(ptr_q + SW'(1));
	assign s_inc    = {1'b0, seqr_q} + MB'(1);
	assign seq_wrap = (s_inc == m_eff) ? '0 : s_inc[QB-1:0];

	// restoring remainder, one bit of base and next per cycle
	assign m10    = {1'b0, m_eff};
	assign tb     = {rb_q, sb_q[QB-1]};
	assign tn     = {rn_q, sn_q[QB-1]};
	assign rb_new = (tb >= m10) ? MB'(tb - m10) : tb[MB-1:0];
	assign rn_new = (tn >= m10) ? MB'(tn - m10) : tn[MB-1:0];

	assign ram_waddr = wslot;

	always_comb begin
		state_d     = state_q;
		base_d      = base_q;
		next_d      = next_q;
		bred_d      = bred_q;
		nred_d      = nred_q;
		count_d     = count_q;
		head_d      = head_q;
		ptr_d       = ptr_q;
		remain_d    = remain_q;
		seqr_d      = seqr_q;
		first_d     = first_q;
		sb_d        = sb_q;
		sn_d        = sn_q;
		rb_d        = rb_q;
		rn_d        = rn_q;
		step_d      = step_q;
		res_d       = '0;
		res_valid_d = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = ptr_q;

		case (state_q)
			gbn_pkg::S_IDLE: begin
				if (accept) begin
					state_d = gbn_pkg::S_EXEC;
				end else if (cfg_wr && cfg_index == gbn_pkg::CFG_MODULUS) begin
					state_d = gbn_pkg::S_NORM;
					sb_d    = base_q;
					sn_d    = next_q;
					rb_d    = '0;
					rn_d    = '0;
					step_d  = '0;
				end
			end

			gbn_pkg::S_EXEC: begin
				state_d = gbn_pkg::S_IDLE;
				case (in_q.opcode)
					gbn_pkg::OP_SEND: begin
						res_valid_d = 1'b1;
						res_d.last  = 1'b1;
						if (full) begin
							res_d.status = gbn_pkg::ST_FULL;
						end else begin
							ram_we               = 1'b1;
							count_d              = count_q + CW'(1);
							res_d.status         = gbn_pkg::ST_SENT;
							res_d.packet_valid   = 1'b1;
							res_d.packet_seq     = nred_q;
							res_d.packet_payload = in_q.payload;
							if (bred_q == nred_q) begin
								res_d.timer_start     = 1'b1;
								res_d.timer_start_seq = bred_q;
							end
							next_d = next_wrap;
							nred_d = next_wrap;
							base_d = bred_q;
						end
					end
					gbn_pkg::OP_ACK: begin
						res_valid_d = 1'b1;
						res_d.last  = 1'b1;
						if (!in_q.ack_checksum_ok) begin
							res_d.status = gbn_pkg::ST_ACK_BAD;
						end else if (ack9 >= m_eff || off_out) begin
							res_d.status = gbn_pkg::ST_ACK_OUT;
						end else begin
							res_d.status         = gbn_pkg::ST_ACK_OK;
							res_d.timer_stop     = 1'b1;
							res_d.timer_stop_seq = bred_q;
							if (count_after != '0) begin
								res_d.timer_start     = 1'b1;
								res_d.timer_start_seq = new_b;
							end
							count_d = count_after;
							head_d  = head_adv;
							base_d  = new_b;
							bred_d  = new_b;
							next_d  = nred_q;
						end
					end
					gbn_pkg::OP_TIMEOUT: begin
						if (count_q == '0) begin
							res_valid_d           = 1'b1;
							res_d.status          = gbn_pkg::ST_TIMEOUT;
							res_d.timer_stop      = 1'b1;
							res_d.timer_stop_seq  = in_q.timer_seq;
							res_d.timer_start     = 1'b1;
							res_d.timer_start_seq = in_q.timer_seq;
							res_d.last            = 1'b1;
						end else begin
							// first read goes out now, data lands in the walk state
							ram_re    = 1'b1;
							ram_raddr = head_q;
							ptr_d     = head_inc;
							remain_d  = count_q;
							seqr_d    = bred_q;
							first_d   = 1'b1;
							state_d   = gbn_pkg::S_RETX;
						end
					end
					default: begin
						state_d = gbn_pkg::S_IDLE;
					end
				endcase
			end

			gbn_pkg::S_RETX: begin
				res_valid_d          = 1'b1;
				res_d.status         = gbn_pkg::ST_TIMEOUT;
				res_d.packet_valid   = 1'b1;
				res_d.packet_seq     = seqr_q;
				res_d.packet_payload = ram_rdata;
				res_d.last           = (remain_q == CW'(1));
				if (first_q) begin
					res_d.timer_stop      = 1'b1;
					res_d.timer_stop_seq  = in_q.timer_seq;
					res_d.timer_start     = 1'b1;
					res_d.timer_start_seq = in_q.timer_seq;
				end
				ram_re   = 1'b1;
				ptr_d    = ptr_inc;
				seqr_d   = seq_wrap;
				remain_d = remain_q - CW'(1);
				first_d  = 1'b0;
				if (remain_q == CW'(1)) begin
					state_d = gbn_pkg::S_IDLE;
				end
			end

			gbn_pkg::S_NORM: begin
				rb_d   = rb_new;
				rn_d   = rn_new;
				sb_d   = {sb_q[QB-2:0], 1'b0};
				sn_d   = {sn_q[QB-2:0], 1'b0};
				step_d = step_q + STW'(1);
				if (step_q == STW'(QB - 1)) begin
					bred_d  = rb_new[QB-1:0];
					nred_d  = rn_new[QB-1:0];
					state_d = gbn_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = gbn_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= gbn_pkg::WIN_RESET;
			mod_q       <= gbn_pkg::MOD_RESET;
			base_q      <= '0;
			next_q      <= '0;
			bred_q      <= '0;
			nred_q      <= '0;
			count_q     <= '0;
			head_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && cfg_index == gbn_pkg::CFG_WINDOW) begin
				win_q <= cfg_data[gbn_pkg::WIN_BITS-1:0];
			end
			if (cfg_wr && cfg_index == gbn_pkg::CFG_MODULUS) begin
				mod_q <= cfg_data;
			end
			base_q      <= base_d;
			next_q      <= next_d;
			bred_q      <= bred_d;
			nred_q      <= nred_d;
			count_q     <= count_d;
			head_q      <= head_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= item;
		end
		res_q    <= res_d;
		ptr_q    <= ptr_d;
		remain_q <= remain_d;
		seqr_q   <= seqr_d;
		first_q  <= first_d;
		sb_q     <= sb_d;
		sn_q     <= sn_d;
		rb_q     <= rb_d;
		rn_q     <= rn_d;
		step_q   <= step_d;
	end

	gbn_ram #(
		.WIDTH (gbn_pkg::PAYLOAD_BITS),
		.DEPTH (MAX_WINDOW)
	) u_window_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_q.payload),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### src/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the go-back-n sender, bound to its top level.
// ----------------------------------------------------------------------------
module gbn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input gbn_pkg::out_item_t result,
	input logic               cfg_ready
);

	// an accepted item raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// results only come out of work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without an item in progress");

	// the final result of an item leaves the block free
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy still high on final result");

	// a retransmit burst has no gaps
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside a result burst");

	// configuration is only taken while no item is in progress
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy)
		else $error("config ready while busy");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result),
	.cfg_ready    (cfg_ready)
);
